// ===== hdl/mau_pkg.sv =====
// Shared types and constants for the modular arithmetic unit.
package mau_pkg;
   localparam int unsigned RES_W = 31;
   localparam int unsigned OP_W = 3;
   localparam int unsigned EXP_W = 63;
   localparam logic [RES_W-1:0] MODULUS_RESET = 31'd1000000007;

   typedef enum logic [OP_W-1:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_POW = 3'd4,
      OP_INV = 3'd5,
      OP_NEG = 3'd6,
      OP_BAD = 3'd7
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_A,
      ST_RED_B,
      ST_DISPATCH,
      ST_EXP_BIT,
      ST_MUL_ACC,
      ST_MUL_SQ,
      ST_FINAL_MUL,
      ST_DONE
   } state_type;

   // Request to the bit-serial multiplier: computes (z * 2^RES_W + x * y) mod m.
   typedef struct packed {
      logic             start;
      logic [RES_W-1:0] x;
      logic [RES_W-1:0] y;
      logic [RES_W-1:0] z;
   } mulreq_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [RES_W-1:0] result;
   } mulrsp_type;
endpackage

// ===== hdl/mau_if.sv =====
// Valid/ready channel interface carrying a payload.
interface mau_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/modular_arithmetic_unit.sv =====
// Top level of the modular arithmetic unit.
// Usage: present op, operand_a, operand_b and exponent on the req channel
// (valid/ready); one residue returns on the rsp channel for each transfer.
// The modulus is written through csr_write_enable/csr_write_data; the user must
// do so only while the unit is idle (not enforced here); it resets to 1000000007.
// One item at a time: req_ready is high only while the sequencer is idle.
// Sequence: both operands are reduced modulo the modulus, then add, sub and
// negate finish without a product; mul runs one product; pow runs a
// square-and-multiply loop over the EXP_BITS exponent bits (one bit-serial
// multiplier, used for the multiply and the square of each exponent bit);
// inverse and divide run the same loop over the bits of modulus minus 2,
// divide adds one more product.
// A modulus below two returns 0 for every opcode.
// Reset is synchronous and clears the sequencer and the rsp valid flag.
// When the receiver stalls, the result waits in the rsp output register
// and no new request is taken until it has been transferred.
module modular_arithmetic_unit #(
   parameter int unsigned EXP_BITS = 63
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [mau_pkg::OP_W-1:0]  req_op,
   input  logic [mau_pkg::RES_W-1:0] req_operand_a,
   input  logic [mau_pkg::RES_W-1:0] req_operand_b,
   input  logic [EXP_BITS-1:0]       req_exponent,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [mau_pkg::RES_W-1:0] rsp_residue,
   input  logic                      csr_write_enable,
   input  logic [mau_pkg::RES_W-1:0] csr_write_data
);
   localparam int unsigned W = mau_pkg::RES_W;
   localparam int unsigned EB = (EXP_BITS > W) ? EXP_BITS : W;
   localparam int unsigned ECW = $clog2(EB + 1);

   typedef struct packed {
      logic [mau_pkg::OP_W-1:0] op;
      logic [W-1:0]             a;
      logic [W-1:0]             b;
      logic [EXP_BITS-1:0]      e;
   } req_type;

   mau_if #(.payload_type(req_type))      req_ch ();
   mau_if #(.payload_type(logic [W-1:0])) rsp_ch ();

   assign req_ch.valid = req_valid;
   assign req_ch.payload = '{op: req_op, a: req_operand_a, b: req_operand_b,
                             e: req_exponent};
   assign req_ready = req_ch.ready;
   assign rsp_valid = rsp_ch.valid;
   assign rsp_residue = rsp_ch.payload;
   assign rsp_ch.ready = rsp_ready;

   mau_pkg::state_type state_ff, state_in;
   logic [W-1:0]        mod_ff;
   logic [W-1:0]        a_ff, b_ff, acc_ff, sq_ff;
   logic [EB-1:0]       e_ff;
   logic [ECW-1:0]      ecnt_ff;
   mau_pkg::op_type     op_ff;
   logic                rvalid_ff;
   logic [W-1:0]        rdata_ff;

   logic                red_start, red_done;
   logic [W-1:0]        red_value, red_result;
   mau_pkg::mulreq_type mreq;
   mau_pkg::mulrsp_type mrsp;

   logic take, mod_small, zero_inv;
   logic [W-1:0] sum_ab, sub_ab, neg_a, early_res;
   logic [W:0]   s_add, s_sub;

   assign take = req_ch.valid && req_ch.ready;
   assign mod_small = (mod_ff < W'(2));
   assign req_ch.ready = (state_ff == mau_pkg::ST_IDLE) && !rvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) mod_ff <= mau_pkg::MODULUS_RESET;
      else if (csr_write_enable) mod_ff <= csr_write_data;
   end

   mau_reduce u_reduce (
      .clock(clock), .reset(reset), .modulus(mod_ff), .start(red_start),
      .value(red_value), .done(red_done), .result(red_result)
   );

   mau_mulmod u_mulmod (
      .clock(clock), .reset(reset), .modulus(mod_ff), .req(mreq), .rsp(mrsp)
   );

   always_comb begin
      s_add = {1'b0, a_ff} + {1'b0, b_ff};
      sum_ab = (s_add >= {1'b0, mod_ff}) ? W'(s_add - {1'b0, mod_ff}) : s_add[W-1:0];
      s_sub = {1'b0, a_ff} + ({1'b0, mod_ff} - {1'b0, b_ff});
      sub_ab = (s_sub >= {1'b0, mod_ff}) ? W'(s_sub - {1'b0, mod_ff}) : s_sub[W-1:0];
      neg_a = (a_ff == '0) ? '0 : mod_ff - a_ff;
      case (op_ff)
         mau_pkg::OP_ADD: early_res = sum_ab;
         mau_pkg::OP_SUB: early_res = sub_ab;
         mau_pkg::OP_NEG: early_res = neg_a;
         default:         early_res = '0;
      endcase
      zero_inv = ((op_ff == mau_pkg::OP_INV) && (a_ff == '0)) ||
                 ((op_ff == mau_pkg::OP_DIV) && (b_ff == '0));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mau_pkg::ST_IDLE:
            if (take) state_in = mau_pkg::ST_RED_A;
         mau_pkg::ST_RED_A:
            if (mod_small) state_in = mau_pkg::ST_DONE;
            else if (red_done) state_in = mau_pkg::ST_RED_B;
         mau_pkg::ST_RED_B:
            if (red_done) state_in = mau_pkg::ST_DISPATCH;
         mau_pkg::ST_DISPATCH:
            case (op_ff)
               mau_pkg::OP_MUL: state_in = mau_pkg::ST_FINAL_MUL;
               mau_pkg::OP_POW, mau_pkg::OP_INV, mau_pkg::OP_DIV:
                  state_in = zero_inv ? mau_pkg::ST_DONE : mau_pkg::ST_EXP_BIT;
               default: state_in = mau_pkg::ST_DONE;
            endcase
         mau_pkg::ST_EXP_BIT:
            if (ecnt_ff == '0)
               state_in = (op_ff == mau_pkg::OP_DIV) ? mau_pkg::ST_FINAL_MUL
                                                     : mau_pkg::ST_DONE;
            else if (e_ff[0]) state_in = mau_pkg::ST_MUL_ACC;
            else state_in = mau_pkg::ST_MUL_SQ;
         mau_pkg::ST_MUL_ACC:
            if (mrsp.done) state_in = mau_pkg::ST_MUL_SQ;
         mau_pkg::ST_MUL_SQ:
            if (mrsp.done) state_in = mau_pkg::ST_EXP_BIT;
         mau_pkg::ST_FINAL_MUL:
            if (mrsp.done) state_in = mau_pkg::ST_DONE;
         mau_pkg::ST_DONE:
            state_in = mau_pkg::ST_IDLE;
         default: state_in = mau_pkg::ST_IDLE;
      endcase
   end

   // outputs to the serial units
   always_comb begin
      red_start = 1'b0;
      red_value = a_ff;
      mreq = '0;
      if (state_ff == mau_pkg::ST_IDLE && take) begin
         red_start = 1'b1;
         red_value = req_ch.payload.a;
      end
      if (state_ff == mau_pkg::ST_RED_A && red_done && !mod_small) begin
         red_start = 1'b1;
         red_value = b_ff;
      end
      if ((state_ff == mau_pkg::ST_DISPATCH && op_ff == mau_pkg::OP_MUL)) begin
         mreq.start = 1'b1; mreq.x = a_ff; mreq.y = b_ff;
      end
      if (state_ff == mau_pkg::ST_EXP_BIT && ecnt_ff != '0) begin
         mreq.start = 1'b1;
         mreq.x = e_ff[0] ? acc_ff : sq_ff;
         mreq.y = sq_ff;
      end
      if (state_ff == mau_pkg::ST_EXP_BIT && ecnt_ff == '0 &&
          op_ff == mau_pkg::OP_DIV) begin
         mreq.start = 1'b1; mreq.x = a_ff; mreq.y = acc_ff;
      end
      if (state_ff == mau_pkg::ST_MUL_ACC && mrsp.done) begin
         mreq.start = 1'b1; mreq.x = sq_ff; mreq.y = sq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mau_pkg::ST_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == mau_pkg::ST_DONE) rvalid_ff <= 1'b1;
         else if (rvalid_ff && rsp_ch.ready) rvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         mau_pkg::ST_IDLE:
            if (take) begin
               op_ff <= mau_pkg::op_type'(req_ch.payload.op);
               b_ff  <= req_ch.payload.b;
               e_ff  <= EB'(req_ch.payload.e);
            end
         mau_pkg::ST_RED_A:
            if (red_done) a_ff <= red_result;
         mau_pkg::ST_RED_B:
            if (red_done) begin
               b_ff <= red_result;
               acc_ff <= W'(1);
               ecnt_ff <= (op_ff != mau_pkg::OP_POW) ? ECW'(W) : ECW'(EXP_BITS);
               if (op_ff != mau_pkg::OP_POW) e_ff <= EB'(mod_ff - W'(2));
            end
         mau_pkg::ST_DISPATCH:
            sq_ff <= (op_ff == mau_pkg::OP_DIV) ? b_ff : a_ff;
         mau_pkg::ST_EXP_BIT:
            if (ecnt_ff != '0) begin
               ecnt_ff <= ecnt_ff - 1'b1;
               e_ff <= e_ff >> 1;
            end
         mau_pkg::ST_MUL_ACC:
            if (mrsp.done) acc_ff <= mrsp.result;
         mau_pkg::ST_MUL_SQ:
            if (mrsp.done) sq_ff <= mrsp.result;
         mau_pkg::ST_FINAL_MUL:
            if (mrsp.done) acc_ff <= mrsp.result;
         default: ;
      endcase
      if (state_ff == mau_pkg::ST_DONE) begin
         if (mod_small || zero_inv) rdata_ff <= '0;
         else case (op_ff)
            mau_pkg::OP_ADD, mau_pkg::OP_SUB, mau_pkg::OP_NEG: rdata_ff <= early_res;
            mau_pkg::OP_MUL, mau_pkg::OP_DIV, mau_pkg::OP_POW,
            mau_pkg::OP_INV: rdata_ff <= acc_ff;
            default: rdata_ff <= '0;
         endcase
      end
   end

   assign rsp_ch.valid = rvalid_ff;
   assign rsp_ch.payload = rdata_ff;

`ifndef SYNTHESIS
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != mau_pkg::ST_IDLE) |-> !req_ready)
      else $error("request taken while busy");
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      (rvalid_ff && !mod_small) |-> (rdata_ff < mod_ff))
      else $error("residue not below modulus");
   a_done_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mau_pkg::ST_DONE) |=> rvalid_ff)
      else $error("result lost");
`endif
endmodule

// ===== hdl/mau_mulmod.sv =====
// Bit-serial modular multiply-add: one multiplier bit per cycle, MSB first.
module mau_mulmod (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [mau_pkg::RES_W-1:0]   modulus,
   input  mau_pkg::mulreq_type         req,
   output mau_pkg::mulrsp_type         rsp
);
   localparam int unsigned W = mau_pkg::RES_W;
   localparam int unsigned CW = $clog2(W + 1);

   logic [W-1:0]  x_ff, y_ff, acc_ff, acc_in;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff, done_ff;
   logic [W+1:0]  dbl, dbl_red, add, add_red;

   // acc = 2*acc mod m, then + x if the current y bit is set (operands below m)
   always_comb begin
      dbl = {2'b0, acc_ff} << 1;
      dbl_red = (dbl >= {2'b0, modulus}) ? dbl - {2'b0, modulus} : dbl;
      add = dbl_red + (y_ff[W-1] ? {2'b0, x_ff} : '0);
      add_red = (add >= {2'b0, modulus}) ? add - {2'b0, modulus} : add;
      acc_in = add_red[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         x_ff   <= req.x;
         y_ff   <= req.y;
         acc_ff <= req.z;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         y_ff   <= y_ff << 1;
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.result = acc_ff;
endmodule

// ===== hdl/mau_reduce.sv =====
// Bit-serial reduction of a 31-bit operand modulo m, one bit per cycle.
module mau_reduce (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [mau_pkg::RES_W-1:0] modulus,
   input  logic                      start,
   input  logic [mau_pkg::RES_W-1:0] value,
   output logic                      done,
   output logic [mau_pkg::RES_W-1:0] result
);
   localparam int unsigned W = mau_pkg::RES_W;
   localparam int unsigned CW = $clog2(W + 1);

   logic [W-1:0]  v_ff, r_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff, done_ff;
   logic [W:0]    sh, sh_red;

   // shift in the next bit, subtract m once (remainder stays below m)
   always_comb begin
      sh = {r_ff, v_ff[W-1]};
      sh_red = (sh >= {1'b0, modulus}) ? sh - {1'b0, modulus} : sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff <= value;
         r_ff <= '0;
      end else if (busy_ff) begin
         v_ff <= v_ff << 1;
         r_ff <= sh_red[W-1:0];
      end
   end

   assign done = done_ff;
   assign result = r_ff;
endmodule

// ===== tb/sv/mau_tb_pkg.sv =====
// Request item type shared by the testbench top and the checker.
package mau_tb_pkg;
   typedef struct packed {
      mau_pkg::op_type           op;
      logic [mau_pkg::RES_W-1:0] operand_a;
      logic [mau_pkg::RES_W-1:0] operand_b;
      logic [mau_pkg::EXP_W-1:0] exponent;
   } req_item_type;
endpackage

// ===== tb/sv/mau_checker.sv =====
// Residue predictor and scoreboard for the modular arithmetic unit.
module mau_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_fire,
   input  mau_tb_pkg::req_item_type  req_item,
   input  logic                      rsp_fire,
   input  logic [mau_pkg::RES_W-1:0] rsp_residue,
   input  logic                      csr_write_enable,
   input  logic [mau_pkg::RES_W-1:0] csr_write_data,
   output int                        error_count,
   output int                        outstanding,
   output int                        checked_count
);
   logic [mau_pkg::RES_W-1:0] modulus;
   logic [mau_pkg::RES_W-1:0] residue_queue[$];

   function automatic longint unsigned mod_pow(longint unsigned base,
                                               logic [mau_pkg::EXP_W-1:0] e,
                                               longint unsigned m);
      longint unsigned acc;
      longint unsigned sq;
      acc = 1 % m;
      sq = base % m;
      for (int i = 0; i < mau_pkg::EXP_W; i++) begin
         if (e[i]) acc = (acc * sq) % m;
         sq = (sq * sq) % m;
      end
      return acc;
   endfunction

   function automatic longint unsigned mod_inv(longint unsigned v, longint unsigned m);
      if (v == 0) return 0;
      return mod_pow(v, mau_pkg::EXP_W'(m - 2), m);
   endfunction

   function automatic logic [mau_pkg::RES_W-1:0] predict_residue(
         mau_tb_pkg::req_item_type it, logic [mau_pkg::RES_W-1:0] mod_value);
      longint unsigned m;
      longint unsigned a;
      longint unsigned b;
      longint unsigned r;
      m = mod_value;
      if (m < 2) return '0;
      a = it.operand_a % m;
      b = it.operand_b % m;
      case (it.op)
         mau_pkg::OP_ADD: r = (a + b) % m;
         mau_pkg::OP_SUB: r = (a + m - b) % m;
         mau_pkg::OP_MUL: r = (a * b) % m;
         mau_pkg::OP_DIV: r = (a * mod_inv(b, m)) % m;
         mau_pkg::OP_POW: r = mod_pow(a, it.exponent, m);
         mau_pkg::OP_INV: r = mod_inv(a, m);
         mau_pkg::OP_NEG: r = (m - a) % m;
         default: r = 0;
      endcase
      return mau_pkg::RES_W'(r);
   endfunction

   assign outstanding = residue_queue.size();

   always @(posedge clock) begin
      logic [mau_pkg::RES_W-1:0] want;
      if (reset) begin
         modulus <= mau_pkg::MODULUS_RESET;
         residue_queue.delete();
         error_count <= 0;
         checked_count <= 0;
      end else begin
         if (csr_write_enable) modulus <= csr_write_data;
         if (req_fire) residue_queue.push_back(predict_residue(req_item, modulus));
         if (rsp_fire) begin
            checked_count <= checked_count + 1;
            if (residue_queue.size() == 0) begin
               if (error_count < 10) $display("ERROR: unexpected residue %0d", rsp_residue);
               error_count <= error_count + 1;
            end else begin
               want = residue_queue.pop_front();
               if (want !== rsp_residue) begin
                  if (error_count < 10)
                     $display("ERROR: residue mismatch: expected %0d, got %0d",
                              want, rsp_residue);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== tb/sv/tb.sv =====
// Testbench top: stimulus, flow control and verdict for modular_arithmetic_unit.
module tb;
   localparam int CYCLE_LIMIT = 4000000;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [mau_pkg::RES_W-1:0] csr_write_data;
   logic idle_on;
   logic pressed;
   int sent_count;
   int cycle_count;
   int error_count;
   int outstanding;
   int checked_count;
   int phase_count;

   mau_if #(.payload_type(mau_tb_pkg::req_item_type)) req_ch ();
   mau_if #(.payload_type(logic [mau_pkg::RES_W-1:0])) rsp_ch ();

   modular_arithmetic_unit #(.EXP_BITS(mau_pkg::EXP_W)) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .req_op(req_ch.payload.op),
      .req_operand_a(req_ch.payload.operand_a),
      .req_operand_b(req_ch.payload.operand_b),
      .req_exponent(req_ch.payload.exponent),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .rsp_residue(rsp_ch.payload),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   mau_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_fire(req_ch.valid && req_ch.ready),
      .req_item(req_ch.payload),
      .rsp_fire(rsp_ch.valid && rsp_ch.ready),
      .rsp_residue(rsp_ch.payload),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .error_count(error_count),
      .outstanding(outstanding),
      .checked_count(checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   // Receiver: random stall bursts, plus one long hold-off to back up the input.
   initial begin
      rsp_ch.ready = 1'b0;
      pressed = 1'b0;
      forever begin
         @(negedge clock);
         if (!pressed && sent_count >= 30) begin
            rsp_ch.ready = 1'b0;
            repeat (3000) @(negedge clock);
            pressed = 1'b1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   task automatic send_item(mau_pkg::op_type op, logic [mau_pkg::RES_W-1:0] a,
                            logic [mau_pkg::RES_W-1:0] b,
                            logic [mau_pkg::EXP_W-1:0] e);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_ch.payload = '{op: op, operand_a: a, operand_b: b, exponent: e};
      req_ch.valid = 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_count++;
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   // Write the modulus only once the unit has drained.
   task automatic set_modulus(logic [mau_pkg::RES_W-1:0] value);
      wait (outstanding == 0);
      repeat (50) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      phase_count++;
   endtask

   function automatic logic [mau_pkg::RES_W-1:0] pick_operand(
         logic [mau_pkg::RES_W-1:0] m);
      case ($urandom_range(0, 4))
         0: return mau_pkg::RES_W'($urandom_range(0, 3));
         1: return m - mau_pkg::RES_W'($urandom_range(0, 1));
         2: return '1;
         default: return mau_pkg::RES_W'($urandom);
      endcase
   endfunction

   task automatic random_items(int count, logic [mau_pkg::RES_W-1:0] m);
      logic [mau_pkg::EXP_W-1:0] e;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 2) == 0) e = mau_pkg::EXP_W'($urandom_range(0, 20));
         else e = mau_pkg::EXP_W'({$urandom, $urandom});
         send_item(mau_pkg::op_type'($urandom_range(0, 7)), pick_operand(m),
                   pick_operand(m), e);
      end
   endtask

   initial begin
      logic [mau_pkg::RES_W-1:0] moduli[8];
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      idle_on = 1'b1;
      sent_count = 0;
      cycle_count = 0;
      phase_count = 0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Directed: every opcode, field extremes, zero inverse and divisor, zero exponent.
      send_item(mau_pkg::OP_ADD, '1, '1, '0);
      send_item(mau_pkg::OP_ADD, 31'd1000000006, 31'd1, '0);
      send_item(mau_pkg::OP_SUB, '0, '1, '0);
      send_item(mau_pkg::OP_SUB, 31'd5, 31'd5, '0);
      send_item(mau_pkg::OP_MUL, '1, '1, '0);
      send_item(mau_pkg::OP_MUL, 31'd1000000006, 31'd1000000006, '0);
      send_item(mau_pkg::OP_DIV, 31'd7, 31'd0, '1);
      send_item(mau_pkg::OP_DIV, 31'd1000000007, 31'd3, '0);
      send_item(mau_pkg::OP_DIV, '1, '1, '0);
      send_item(mau_pkg::OP_POW, 31'd0, '0, '0);
      send_item(mau_pkg::OP_POW, 31'd2, '0, '0);
      send_item(mau_pkg::OP_POW, '1, '0, '1);
      send_item(mau_pkg::OP_POW, 31'd3, '1, 63'h2AAA_AAAA_AAAA_AAAA);
      send_item(mau_pkg::OP_POW, 31'd0, '0, 63'd5);
      send_item(mau_pkg::OP_INV, 31'd0, '0, '0);
      send_item(mau_pkg::OP_INV, 31'd2000000014, '0, '0);
      send_item(mau_pkg::OP_INV, '1, '1, '1);
      send_item(mau_pkg::OP_NEG, '0, '0, '0);
      send_item(mau_pkg::OP_NEG, '1, '0, '0);
      send_item(mau_pkg::OP_BAD, '1, '1, '1);
      random_items(30, mau_pkg::MODULUS_RESET);

      // Largest prime, smallest prime, below-two moduli, small and composite ones.
      moduli = '{31'h7FFF_FFFF, 31'd2, 31'd0, 31'd3, 31'd1, 31'd65537, 31'd15, 31'd97};
      foreach (moduli[k]) begin
         set_modulus(moduli[k]);
         send_item(mau_pkg::OP_INV, moduli[k] + 31'd1, '0, '0);
         send_item(mau_pkg::OP_DIV, '1, moduli[k], '0);
         random_items(8, moduli[k]);
      end
      set_modulus(mau_pkg::MODULUS_RESET);
      idle_on = 1'b0;
      random_items(12, mau_pkg::MODULUS_RESET);

      wait (outstanding == 0);
      repeat (100) @(negedge clock);
      $display("Ran %0d requests over %0d modulus settings, %0d residues checked",
               sent_count, phase_count + 1, checked_count);
      $display("Covered all opcodes, zero divisor and inverse, moduli 0 to 2^31-1");
      if (error_count == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

// ===== files.f =====
hdl/mau_pkg.sv
hdl/mau_if.sv
hdl/mau_mulmod.sv
hdl/mau_reduce.sv
hdl/modular_arithmetic_unit.sv
tb/sv/mau_tb_pkg.sv
tb/sv/mau_checker.sv
tb/sv/tb.sv
